### rtl/spc_pkg.sv
// Shared types and constants for the stack permutation checker.
package spc_pkg;

  localparam int VAL_W = 6;
  localparam int CNT_W = 7;
  localparam int MAX_VALUE_DEF = 63;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_FAIL = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0] target;
    logic             start_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [VAL_W-1:0] moved_value;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] target;
    logic             start_req;
    logic             in_range;
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_PUSH
  } back_state_t;

endpackage

### rtl/spc_fifo.sv
// Small synchronous queue with registered storage.
module spc_fifo import spc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  parameter int WIDTH = $bits(cmd_t)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_QW-1:0]  fill;
  logic               do_wr;
  logic               do_rd;

  assign full  = (fill == CNT_QW'(DEPTH));
  assign empty = (fill == '0);
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### rtl/spc_front.sv
// Input stage: take a request, check its target range, hand it on as a command.
module spc_front import spc_pkg::*; #(
  parameter int MAX_VALUE = MAX_VALUE_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t item,
  output logic     full,
  output logic     cmd_push,
  output cmd_t     cmd,
  input  logic     cmd_full
);

  logic hold_valid;
  logic take;
  logic drain;

  assign drain    = hold_valid && !cmd_full;
  assign full     = hold_valid && cmd_full;
  assign take     = push && !full;
  assign cmd_push = hold_valid;

  always_ff @(posedge clk) begin
    if (take) begin
      cmd.target    <= item.target;
      cmd.start_req <= item.start_req;
      cmd.in_range  <= ({1'b0, item.target} <= CNT_W'(MAX_VALUE));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (drain) begin
      hold_valid <= 1'b0;
    end
  end

endmodule

### rtl/spc_back.sv
// Execution stage: stack, push counter and failure flag; emits push/pop/fail results.
module spc_back import spc_pkg::*; #(
  parameter int MAX_VALUE = MAX_VALUE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_empty,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      res_push,
  output out_item_t res,
  input  logic      res_full
);

  localparam int ADDR_W = (MAX_VALUE > 1) ? $clog2(MAX_VALUE) : 1;

  logic [VAL_W-1:0] stack_mem [MAX_VALUE];

  back_state_t      state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] nxt, nxt_next;
  logic             failed, failed_next;
  logic             src_mem, src_mem_next;
  logic [VAL_W-1:0] top;
  logic [VAL_W-1:0] rd_q;
  logic [VAL_W-1:0] tgt;
  logic             tgt_ok;

  logic [CNT_W-1:0] count_e;
  logic [CNT_W-1:0] nxt_e;
  logic             fail_e;
  logic [VAL_W-1:0] cur_target;
  logic             cur_ok;
  logic [VAL_W-1:0] top_eff;
  logic             need_push;
  logic             active;
  logic             drop;
  logic             do_push;
  logic             do_pop;
  logic             do_fail;
  logic             fire;
  logic             commit;
  logic [CNT_W-1:0] pop_cnt;
  logic [ADDR_W-1:0] wr_idx;
  logic [ADDR_W-1:0] rd_idx;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (fire && do_push) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (fire && !do_push) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Decisions and outputs.
  always_comb begin
    if (state == ST_IDLE) begin
      count_e    = cmd.start_req ? '0 : count;
      nxt_e      = cmd.start_req ? CNT_W'(1) : nxt;
      fail_e     = cmd.start_req ? 1'b0 : failed;
      cur_target = cmd.target;
      cur_ok     = cmd.in_range;
      active     = !cmd_empty && !fail_e;
      drop       = !cmd_empty && fail_e;
    end else begin
      count_e    = count;
      nxt_e      = nxt;
      fail_e     = failed;
      cur_target = tgt;
      cur_ok     = tgt_ok;
      active     = 1'b1;
      drop       = 1'b0;
    end
    top_eff   = src_mem ? rd_q : top;
    need_push = cur_ok && (nxt_e <= {1'b0, cur_target});
    do_push   = active && need_push;
    do_pop    = active && !need_push && cur_ok && (count_e != '0) && (top_eff == cur_target);
    do_fail   = active && !need_push && !do_pop;
    res_push  = active;
    fire      = active && !res_full;
    cmd_pop   = (state == ST_IDLE) && !cmd_empty && (drop || fire);
    commit    = cmd_pop || ((state == ST_PUSH) && fire);

    res.op          = OP_FAIL;
    res.moved_value = '0;
    res.last        = 1'b1;
    if (do_push) begin
      res.op          = OP_PUSH;
      res.moved_value = nxt_e[VAL_W-1:0];
      res.last        = 1'b0;
    end else if (do_pop) begin
      res.op          = OP_POP;
      res.moved_value = cur_target;
    end

    count_next   = count;
    nxt_next     = nxt;
    failed_next  = failed;
    src_mem_next = src_mem;
    if (commit) begin
      count_next  = count_e;
      nxt_next    = nxt_e;
      failed_next = fail_e;
      if (do_push) begin
        count_next   = count_e + 1'b1;
        nxt_next     = nxt_e + 1'b1;
        src_mem_next = 1'b0;
      end else if (do_pop) begin
        count_next   = count_e - 1'b1;
        src_mem_next = 1'b1;
      end else if (do_fail) begin
        failed_next  = 1'b1;
      end
    end

    pop_cnt = count_e - CNT_W'(2);
    wr_idx  = count_e[ADDR_W-1:0];
    rd_idx  = pop_cnt[ADDR_W-1:0];
  end

  // Stack storage: write on push, read the entry below the top on pop.
  always_ff @(posedge clk) begin
    if (fire && do_push) begin
      stack_mem[wr_idx] <= nxt_e[VAL_W-1:0];
    end
    if (fire && do_pop) begin
      rd_q <= stack_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (fire && do_push) begin
      top <= nxt_e[VAL_W-1:0];
    end
    if (state == ST_IDLE && fire && do_push) begin
      tgt    <= cmd.target;
      tgt_ok <= cmd.in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      nxt     <= CNT_W'(1);
      failed  <= 1'b0;
      src_mem <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      nxt     <= nxt_next;
      failed  <= failed_next;
      src_mem <= src_mem_next;
    end
  end

endmodule

### rtl/stack_permutation_checker.sv
// Stack permutation checker: one wanted value per request in, push/pop/fail results out.
// Path: a request passes the front register and then the command queue on its way to the
//   stack engine; its results are read from the result queue.
// Throughput: one result per cycle while the result queue has room; a request gives one push
//   result per push, then one pop or fail result, and a dropped request gives none.
// Reset: synchronous, active high; empties both queues, clears the stack and failure flag,
//   and sets the push counter to one. Stack contents are not cleared.
module stack_permutation_checker import spc_pkg::*; #(
  parameter int MAX_VALUE   = MAX_VALUE_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  in_item_t  item,
  output logic      full,
  input  logic      pop,
  output out_item_t result,
  output logic      empty
);

  // Command path between the front and the stack engine.
  logic      cmd_push;
  cmd_t      cmd_in;
  logic      cmd_full;
  logic      cmd_pop;
  cmd_t      cmd_out;
  logic      cmd_empty;

  // Result path from the stack engine to the output queue.
  logic      res_push;
  out_item_t res;
  logic      res_full;

  // Front: hold one request and tag targets above the counter range.
  spc_front #(
    .MAX_VALUE (MAX_VALUE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  // Decouple the front from the stack engine so each can stall on its own.
  spc_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(cmd_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  // Stack engine: advance the push counter, pop on a match, fail otherwise, drop requests while failed.
  spc_back #(
    .MAX_VALUE (MAX_VALUE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  // Result queue: hold finished results until the consumer pops them.
  spc_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(out_item_t))
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule
